/* hdl/uart_command_line_receiver_unit_macros.svh */
// assertion helpers for the command line receiver
`ifndef UART_COMMAND_LINE_RECEIVER_UNIT_MACROS_SVH
`define UART_COMMAND_LINE_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define UCL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define UCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ucl_pkg.sv */
`timescale 1ns / 1ps
package ucl_pkg;
   localparam int LINE_MAX_DEFAULT = 20;

   localparam logic [7:0] CH_LOW  = 8'h20;
   localparam logic [7:0] CH_HIGH = 8'h7E;
   localparam logic [7:0] CH_CR   = 8'h0D;

   localparam logic FUNC_RX  = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   // bank bit plus line index for the default line length
   localparam int RAM_ADDR_W_DEFAULT = $clog2(LINE_MAX_DEFAULT) + 1;

   typedef struct packed {
      logic printable;
      logic cr;
   } rx_class_type;

   function automatic rx_class_type classify(input logic [7:0] ch);
      rx_class_type c;
      c.printable = (ch >= CH_LOW) && (ch <= CH_HIGH);
      c.cr        = (ch == CH_CR);
      return c;
   endfunction
endpackage

/* hdl/uart_command_line_receiver_unit.sv */
`timescale 1ns / 1ps
// command line receiver: a received byte beat (func 0) is taken and gives no
// result; printable characters are appended to the line until it holds
// LINE_MAX-1 of them and a carriage return hands the line over as the pending
// command unless one is already waiting. a get beat (func 1) answers with the
// pending command, one result beat per character and a closing zero with last
// set, or with a single has_command 0 beat when nothing waits. a command is
// streamed through the single ram read port that the stepping counter walks one
// entry at a time (read state, then result state). the two line buffers share
// one ram as two banks that swap on hand-over, so no copy pass is needed.
// req_stall is high from a get beat until its last result beat has been taken;
// no clearing pass follows reset.
module uart_command_line_receiver_unit #(
   parameter int LINE_MAX = ucl_pkg::LINE_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_command,
   output logic [7:0] rsp_cmd_byte,
   output logic       rsp_last
);
   localparam int IDX_W  = $clog2(LINE_MAX);
   localparam int ADDR_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] FULL = IDX_W'(LINE_MAX - 1);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]       state_ff,      state_in;
   logic [IDX_W-1:0] line_count_ff, line_count_in;
   logic [IDX_W-1:0] cmd_len_ff,    cmd_len_in;
   logic [IDX_W-1:0] idx_ff,        idx_in;
   logic             pending_ff,    pending_in;
   logic             line_bank_ff,  line_bank_in;   // command bank is the other one
   logic             has_ff,        has_in;
   logic             last_ff,       last_in;

   logic              req_beat;
   logic              rsp_beat;
   ucl_pkg::rx_class_type rx_class;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [IDX_W-1:0]  idx_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign rx_class  = ucl_pkg::classify(req_rx_byte);

   // line writes go to the line bank, stream reads to the command bank
   assign wr_addr  = {line_bank_ff, line_count_ff};
   assign rd_addr  = {~line_bank_ff, idx_ff};
   assign wr_en    = req_beat && (req_func == ucl_pkg::FUNC_RX) && rx_class.printable
                     && (line_count_ff < FULL);
   assign rd_en    = (state_ff == ST_READ);
   assign idx_next = idx_ff + IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      line_count_in = line_count_ff;
      cmd_len_in    = cmd_len_ff;
      idx_in        = idx_ff;
      pending_in    = pending_ff;
      line_bank_in  = line_bank_ff;
      has_in        = has_ff;
      last_in       = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_func == ucl_pkg::FUNC_RX) begin
                  if (wr_en) begin
                     line_count_in = line_count_ff + IDX_W'(1);
                  end
                  if (rx_class.cr) begin
                     // hand the line over by swapping banks, unless one waits
                     if (!pending_ff) begin
                        pending_in   = 1'b1;
                        cmd_len_in   = line_count_ff;
                        line_bank_in = ~line_bank_ff;
                     end
                     line_count_in = '0;
                  end
               end else begin
                  idx_in = '0;
                  if (!pending_ff) begin
                     // nothing waiting: single none beat
                     has_in   = 1'b0;
                     last_in  = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     pending_in = 1'b0;
                     has_in     = 1'b1;
                     if (cmd_len_ff == '0) begin
                        last_in  = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        last_in  = 1'b0;
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_beat) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_next;
                  if (idx_next == cmd_len_ff) begin
                     // terminator beat needs no read
                     last_in  = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_count_ff <= '0;
         pending_ff    <= 1'b0;
         line_bank_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         line_count_ff <= line_count_in;
         pending_ff    <= pending_in;
         line_bank_ff  <= line_bank_in;
      end
   end

   // payload and stream registers
   always_ff @(posedge clock) begin
      cmd_len_ff <= cmd_len_in;
      idx_ff     <= idx_in;
      has_ff     <= has_in;
      last_ff    <= last_in;
   end

   ucl_line_ram #(
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram data holds between reads, so a stalled beat stays put
   assign rsp_has_command = has_ff;
   assign rsp_last        = last_ff;
   assign rsp_cmd_byte    = last_ff ? 8'h00 : rd_data;

`include "uart_command_line_receiver_unit_macros.svh"

   `UCL_ASSERT_IMP(a_no_rsp_when_ready, !req_stall, !rsp_valid, "result beat while taking input")
   `UCL_ASSERT_NEXT(a_idle_after_last, rsp_beat && rsp_last, !req_stall, "not ready after last beat")
   `UCL_ASSERT_IMP(a_none_is_last, rsp_valid && !rsp_has_command, rsp_last, "none beat not last")
   `UCL_ASSERT_IMP(a_last_is_zero, rsp_valid && rsp_last, rsp_cmd_byte == 8'h00, "last beat not zero")
endmodule

/* hdl/ucl_line_ram.sv */
`timescale 1ns / 1ps
module ucl_line_ram #(
   parameter int ADDR_W = ucl_pkg::RAM_ADDR_W_DEFAULT
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
